@@ rtl/ftm_pkg.sv @@
package ftm_pkg;

	localparam int FRAC_BITS = 16;
	localparam int INT_BITS = 8;

	localparam int IN_W = INT_BITS + FRAC_BITS;
	localparam int OUT_W = FRAC_BITS + 1;

	localparam int CW = FRAC_BITS + 2;
	localparam int T_W = IN_W + CW - FRAC_BITS + 1;
	localparam int NUM_W = IN_W + T_W - FRAC_BITS;
	localparam int DEN_W = NUM_W + 1;
	localparam int REM_W = DEN_W + 1;

	localparam logic [CW-1:0] COEF_A = CW'(((64'd251 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [CW-1:0] COEF_B = CW'(((64'd3 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [CW-1:0] COEF_C = CW'(((64'd243 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [CW-1:0] COEF_D = CW'(((64'd59 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [CW-1:0] COEF_E = CW'(((64'd14 << FRAC_BITS) + 64'd50) / 64'd100);

	localparam int LATENCY = 4 + OUT_W;

	typedef struct packed {
		logic [IN_W-1:0] red_in;
		logic [IN_W-1:0] green_in;
		logic [IN_W-1:0] blue_in;
	} pixel_t;

	typedef struct packed {
		logic [OUT_W-1:0] red_out;
		logic [OUT_W-1:0] green_out;
		logic [OUT_W-1:0] blue_out;
	} result_t;

endpackage

@@ rtl/ftm_channel.sv @@
module ftm_channel
	import ftm_pkg::*;
(
	input  logic             clk,
	input  logic [IN_W-1:0]  x,
	output logic [OUT_W-1:0] y
);

	localparam int Q_BITS = OUT_W;

	logic [IN_W-1:0]    x_s1;
	logic [IN_W-1:0]    x_s2;
	logic [T_W-1:0]     t_s2;
	logic [T_W-1:0]     u_s2;
	logic [NUM_W-1:0]   num_s3;
	logic [DEN_W-1:0]   den_s3;

	logic [IN_W+CW-1:0]  prod_a;
	logic [IN_W+CW-1:0]  prod_c;
	logic [IN_W+T_W-1:0] prod_t;
	logic [IN_W+T_W-1:0] prod_u;

	logic               sat0;
	logic               ge0;
	logic [REM_W-1:0]   rem0;

	logic [REM_W-1:0]   rem_s  [Q_BITS];
	logic [DEN_W-1:0]   den_s  [Q_BITS];
	logic [Q_BITS-1:0]  quo_s  [Q_BITS];
	logic               sat_s  [Q_BITS];

	logic [REM_W-1:0]   shifted  [1:Q_BITS-1];
	logic               ge       [1:Q_BITS-1];
	logic [REM_W-1:0]   rem_next [1:Q_BITS-1];

	assign prod_a = (IN_W+CW)'(x_s1) * (IN_W+CW)'(COEF_A);
	assign prod_c = (IN_W+CW)'(x_s1) * (IN_W+CW)'(COEF_C);
	assign prod_t = (IN_W+T_W)'(x_s2) * (IN_W+T_W)'(t_s2);
	assign prod_u = (IN_W+T_W)'(x_s2) * (IN_W+T_W)'(u_s2);

	always_ff @(posedge clk) begin
		x_s1   <= x;
		x_s2   <= x_s1;
		t_s2   <= T_W'(prod_a >> FRAC_BITS) + T_W'(COEF_B);
		u_s2   <= T_W'(prod_c >> FRAC_BITS) + T_W'(COEF_D);
		num_s3 <= NUM_W'(prod_t >> FRAC_BITS);
		den_s3 <= DEN_W'(prod_u >> FRAC_BITS) + DEN_W'(COEF_E);
	end

	always_comb begin
		sat0 = REM_W'(num_s3) >= {den_s3, 1'b0};
		ge0  = DEN_W'(num_s3) >= den_s3;
		rem0 = ge0 ? REM_W'(DEN_W'(num_s3) - den_s3) : REM_W'(num_s3);
	end

	always_comb begin
		for (int k = 1; k < Q_BITS; k++) begin
			shifted[k]  = {rem_s[k-1][REM_W-2:0], 1'b0};
			ge[k]       = shifted[k] >= REM_W'(den_s[k-1]);
			rem_next[k] = ge[k] ? shifted[k] - REM_W'(den_s[k-1]) : shifted[k];
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= rem0;
		den_s[0] <= den_s3;
		quo_s[0] <= Q_BITS'(ge0);
		sat_s[0] <= sat0;
		for (int k = 1; k < Q_BITS; k++) begin
			rem_s[k] <= rem_next[k];
			den_s[k] <= den_s[k-1];
			quo_s[k] <= {quo_s[k-1][Q_BITS-2:0], ge[k]};
			sat_s[k] <= sat_s[k-1];
		end
	end

	assign y = sat_s[Q_BITS-1] ? {OUT_W{1'b1}} : quo_s[Q_BITS-1];

endmodule

@@ rtl/filmic_tone_map_rgb.sv @@
// Filmic tone mapper for one RGB pixel per transaction. Each unsigned Q8.16 channel is
// mapped by the rational curve y = x(ax + b) / (x(cx + d) + e) and returned as a
// saturated Q1.16 value. A pixel is taken on every clock cycle in which start is high;
// busy never rises. The result is on result with done high for exactly one cycle, and
// the receiver cannot stall it. The pipeline is an input register, two multiply stages,
// a divider that resolves one quotient bit per stage, seventeen stages per channel, and
// an output register, all three channels side by side.
module filmic_tone_map_rgb
	import ftm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  pixel_t  pixel,
	output logic    done,
	output result_t result
);

	logic [LATENCY-2:0] valid_q;
	logic               done_q;
	result_t            result_q;
	logic [OUT_W-1:0]   red_y;
	logic [OUT_W-1:0]   green_y;
	logic [OUT_W-1:0]   blue_y;

	assign busy = 1'b0;

	ftm_channel u_red (
		.clk (clk),
		.x   (pixel.red_in),
		.y   (red_y)
	);

	ftm_channel u_green (
		.clk (clk),
		.x   (pixel.green_in),
		.y   (green_y)
	);

	ftm_channel u_blue (
		.clk (clk),
		.x   (pixel.blue_in),
		.y   (blue_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			valid_q <= {valid_q[LATENCY-3:0], start && !busy};
			done_q  <= valid_q[LATENCY-2];
		end
	end

	always_ff @(posedge clk) begin
		result_q.red_out   <= red_y;
		result_q.green_out <= green_y;
		result_q.blue_out  <= blue_y;
	end

	assign done   = done_q;
	assign result = result_q;

	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("Result strobe without a matching accepted transaction.");

	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("Accepted transaction produced no result.");

	a_zero_red: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(pixel.red_in == '0, LATENCY)) |-> (result.red_out == '0))
		else $error("Black red channel did not map to zero.");

	a_zero_blue: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(pixel.blue_in == '0, LATENCY)) |-> (result.blue_out == '0))
		else $error("Black blue channel did not map to zero.");

endmodule

@@ bench/tb_top.sv @@
module tb_top
	import ftm_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD = 10;
	localparam int N_RANDOM = 1634;
	localparam int N_CALM_TAIL = 200;
	localparam int STALL_LIMIT = 1000;

	// Curve coefficients, scaled by 2^FRAC_BITS and rounded to nearest.
	localparam bit [63:0] CURVE_A = ((64'd251 << FRAC_BITS) + 64'd50) / 64'd100;
	localparam bit [63:0] CURVE_B = ((64'd3 << FRAC_BITS) + 64'd50) / 64'd100;
	localparam bit [63:0] CURVE_C = ((64'd243 << FRAC_BITS) + 64'd50) / 64'd100;
	localparam bit [63:0] CURVE_D = ((64'd59 << FRAC_BITS) + 64'd50) / 64'd100;
	localparam bit [63:0] CURVE_E = ((64'd14 << FRAC_BITS) + 64'd50) / 64'd100;
	localparam bit [63:0] TONE_MAX = (64'd1 << (FRAC_BITS + 1)) - 64'd1;
	localparam logic [OUT_W-1:0] TONE_ONE = OUT_W'(1) << FRAC_BITS;

	typedef struct packed {
		pixel_t  px;
		logic    typed;
		result_t want;
	} pixel_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	pixel_t  pixel = '0;
	logic    busy;
	logic    done;
	result_t result;

	result_t pixel_want = '0;
	result_t tone_q[$];

	int n_sent = 0;
	int n_checked = 0;
	int n_err = 0;
	int n_zero_ch = 0;
	int n_over_one_ch = 0;
	int stall_cycles = 0;

	pixel_row_t pixel_rows [0:15] = '{
		'{'{24'h000000, 24'h000000, 24'h000000}, 1'b1, '0},
		'{'{24'h000001, 24'h000010, 24'h000020}, 1'b1, '0},
		'{'{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b0, '0},
		'{'{24'hFFFFFF, 24'h000000, 24'h000000}, 1'b0, '0},
		'{'{24'h000000, 24'hFFFFFF, 24'h000000}, 1'b0, '0},
		'{'{24'h000000, 24'h000000, 24'hFFFFFF}, 1'b0, '0},
		'{'{24'h010000, 24'h010000, 24'h010000}, 1'b0, '0},
		'{'{24'hAAAAAA, 24'h555555, 24'hAAAAAA}, 1'b0, '0},
		'{'{24'h555555, 24'hAAAAAA, 24'h555555}, 1'b0, '0},
		'{'{24'h800000, 24'h400000, 24'h200000}, 1'b0, '0},
		'{'{24'h008000, 24'h004000, 24'h002000}, 1'b0, '0},
		'{'{24'h000100, 24'h000080, 24'h000040}, 1'b0, '0},
		'{'{24'h000021, 24'h000022, 24'h000064}, 1'b0, '0},
		'{'{24'h7FFFFF, 24'hFFFFFE, 24'h0FFFFF}, 1'b0, '0},
		'{'{24'h020000, 24'h030000, 24'h0C0000}, 1'b0, '0},
		'{'{24'h00FFFF, 24'h010001, 24'h004CCC}, 1'b0, '0}
	};

	filmic_tone_map_rgb u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.pixel  (pixel),
		.done   (done),
		.result (result)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [OUT_W-1:0] filmic_curve(input logic [IN_W-1:0] level);
		bit [63:0] x;
		bit [63:0] shoulder;
		bit [63:0] num;
		bit [63:0] toe;
		bit [63:0] den;
		bit [63:0] ratio;
		x = 64'(level);
		shoulder = ((CURVE_A * x) >> FRAC_BITS) + CURVE_B;
		num = (x * shoulder) >> FRAC_BITS;
		toe = ((CURVE_C * x) >> FRAC_BITS) + CURVE_D;
		den = ((x * toe) >> FRAC_BITS) + CURVE_E;
		if (num >= 64'd2 * den) begin
			ratio = TONE_MAX;
		end else begin
			ratio = (num << FRAC_BITS) / den;
			if (ratio > TONE_MAX) begin
				ratio = TONE_MAX;
			end
		end
		return ratio[OUT_W-1:0];
	endfunction

	function automatic result_t tone_map(input pixel_t px);
		result_t mapped;
		mapped.red_out = filmic_curve(px.red_in);
		mapped.green_out = filmic_curve(px.green_in);
		mapped.blue_out = filmic_curve(px.blue_in);
		return mapped;
	endfunction

	// Mixes black, deep shadows, mid tones around 1.0, single bits, near-white and
	// the full input range, so that every input bit is seen both high and low.
	function automatic logic [IN_W-1:0] rand_channel();
		logic [IN_W-1:0] level;
		case ($urandom_range(0, 7))
			0: begin
				level = '0;
			end
			1: begin
				level = IN_W'($urandom_range(0, 255));
			end
			2: begin
				level = IN_W'($urandom_range(32'h4000, 32'h40000));
			end
			5: begin
				level = {IN_W{1'b1}} - IN_W'($urandom_range(0, 4095));
			end
			6: begin
				level = IN_W'(1) << $urandom_range(0, IN_W - 1);
			end
			7: begin
				level = IN_W'($urandom_range(0, 32'hFFFF));
			end
			default: begin
				level = IN_W'($urandom());
			end
		endcase
		return level;
	endfunction

	function automatic int idle_gap(input int rate);
		return ($urandom_range(0, 7) < rate) ? $urandom_range(1, 10) : 0;
	endfunction

	task automatic send_pixel(input pixel_t px, input logic typed, input result_t want,
			input int gap);
		bit taken;
		start <= 1'b1;
		pixel <= px;
		pixel_want <= typed ? want : tone_map(px);
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic hold_until_drained();
		start <= 1'b0;
		do begin
			@(posedge clk);
		end while (tone_q.size() != 0);
	endtask

	task automatic check_field(input string name, input logic [OUT_W-1:0] want,
			input logic [OUT_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected 0x%05h, actual 0x%05h",
				$time, name, want, got);
			n_err++;
		end
		if (got == '0) begin
			n_zero_ch++;
		end
		if (got > TONE_ONE) begin
			n_over_one_ch++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (start && !busy) begin
				tone_q.push_back(pixel_want);
				n_sent++;
			end
			if (done === 1'b1) begin
				if (tone_q.size() == 0) begin
					$display("%0t ns: unexpected transaction, expected none, actual 0x%h",
						$time, result);
					n_err++;
				end else begin
					want = tone_q.pop_front();
					check_field("red_out", want.red_out, result.red_out);
					check_field("green_out", want.green_out, result.green_out);
					check_field("blue_out", want.blue_out, result.blue_out);
					n_checked++;
				end
			end
			if ((start && !busy) || done === 1'b1) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t ns: no transaction for %0d cycles, %0d results outstanding",
					$time, STALL_LIMIT, tone_q.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		int gap_rate;
		pixel_t px;
		gap_rate = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (pixel_rows[i]) begin
			send_pixel(pixel_rows[i].px, pixel_rows[i].typed, pixel_rows[i].want,
				idle_gap(2));
		end
		hold_until_drained();

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 64 == 0) begin
				gap_rate = $urandom_range(0, 3);
			end
			if (i == N_RANDOM / 2) begin
				hold_until_drained();
			end
			px.red_in = rand_channel();
			px.green_in = rand_channel();
			px.blue_in = rand_channel();
			send_pixel(px, 1'b0, '0, (i >= N_RANDOM - N_CALM_TAIL) ? 0 : idle_gap(gap_rate));
		end
		hold_until_drained();
		repeat (LATENCY + 4) @(posedge clk);

		$display("Mapped %0d pixels (%0d table rows, the rest random) and checked %0d results.",
			n_sent, $size(pixel_rows), n_checked);
		$display("Channel results: %0d black, %0d above 1.0, %0d errors.",
			n_zero_ch, n_over_one_ch, n_err);
		if (n_err == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/ftm_pkg.sv
rtl/ftm_channel.sv
rtl/filmic_tone_map_rgb.sv
bench/tb_top.sv
